[sv/rasr_pkg.sv]
package rasr_pkg;

  // operation codes carried on the input side-band
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_RED = 2'd2;

  // multiplier operand selection
  localparam logic [1:0] MUL_AN_BD = 2'd0;
  localparam logic [1:0] MUL_BN_AD = 2'd1;
  localparam logic [1:0] MUL_AD_BD = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } rasr_cmd_t;

  typedef struct packed {
    logic reduce_only;
    logic gcd_done;
  } rasr_sts_t;

endpackage

[sv/rasr_dp.sv]
module rasr_dp import rasr_pkg::*; #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rasr_cmd_t         cmd,
  output rasr_sts_t         sts,
  input  logic [1:0]        in_kind,
  input  logic [W-1:0]      in_a_num,
  input  logic [W-2:0]      in_a_den,
  input  logic [W-1:0]      in_b_num,
  input  logic [W-2:0]      in_b_den,
  output logic [2*W-1:0]    res_num,
  output logic [2*W-3:0]    res_den
);

  localparam int PW = 2 * W;
  localparam int KW = $clog2(PW);

  logic [1:0]    kind_r;
  logic [W-1:0]  an_r, bn_r;
  logic [W-2:0]  ad_r, bd_r;
  logic [PW-1:0] t1_r, t2_r, dd_r;
  logic          neg_r;
  logic [PW-1:0] u_r, v_r, g_r;
  logic [KW-1:0] k_r;
  logic [PW-1:0] q1_r, q2_r, rem1_r, rem2_r;
  logic [PW-1:0] res_num_r;
  logic [PW-3:0] res_den_r;

  logic [W-2:0]         ad_in, bd_in;
  logic signed [W-1:0]  mx;
  logic [W-2:0]         my;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        num_c, den_c, mag_c, an_ext;
  logic [PW-1:0]        u_nxt, v_nxt;
  logic [KW-1:0]        k_nxt;
  logic [PW:0]          sh1, sh2, sub1, sub2;
  logic                 ge1, ge2;

  // a zero denominator counts as one
  assign ad_in = (in_a_den == '0) ? {{(W-2){1'b0}}, 1'b1} : in_a_den;
  assign bd_in = (in_b_den == '0) ? {{(W-2){1'b0}}, 1'b1} : in_b_den;

  always_comb begin
    case (cmd.mul_sel)
      MUL_AN_BD: begin
        mx = an_r;
        my = bd_r;
      end
      MUL_BN_AD: begin
        mx = bn_r;
        my = ad_r;
      end
      default: begin
        mx = {1'b0, ad_r};
        my = bd_r;
      end
    endcase
  end

  assign prod = mx * $signed({1'b0, my});

  assign an_ext = {{W{an_r[W-1]}}, an_r};

  always_comb begin
    if (kind_r[1]) begin
      num_c = an_ext;
      den_c = {{(W+1){1'b0}}, ad_r};
    end else begin
      num_c = (kind_r == KIND_SUB) ? (t1_r - t2_r) : (t1_r + t2_r);
      den_c = dd_r;
    end
    mag_c = num_c[PW-1] ? (~num_c + 1'b1) : num_c;
  end

  // binary GCD step: strip common twos into k, halve the even one,
  // otherwise replace the larger by half the difference
  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    k_nxt = k_r;
    if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + 1'b1;
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r >= v_r) begin
      u_nxt = (u_r - v_r) >> 1;
    end else begin
      v_nxt = (v_r - u_r) >> 1;
    end
  end

  // two restoring dividers sharing the divisor
  assign sh1  = {rem1_r, q1_r[PW-1]};
  assign sh2  = {rem2_r, q2_r[PW-1]};
  assign sub1 = sh1 - {1'b0, g_r};
  assign sub2 = sh2 - {1'b0, g_r};
  assign ge1  = ~sub1[PW];
  assign ge2  = ~sub2[PW];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      an_r   <= in_a_num;
      ad_r   <= ad_in;
      bn_r   <= in_b_num;
      bd_r   <= bd_in;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_AN_BD: t1_r <= prod;
        MUL_BN_AD: t2_r <= prod;
        default:   dd_r <= prod;
      endcase
    end
    if (cmd.gcd_init) begin
      neg_r <= num_c[PW-1];
      u_r   <= mag_c;
      v_r   <= den_c;
      k_r   <= '0;
      q1_r  <= mag_c;
      q2_r  <= den_c;
    end
    if (cmd.gcd_step) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      k_r <= k_nxt;
    end
    if (cmd.div_init) begin
      g_r    <= v_r << k_r;
      rem1_r <= '0;
      rem2_r <= '0;
    end
    if (cmd.div_step) begin
      rem1_r <= ge1 ? sub1[PW-1:0] : sh1[PW-1:0];
      rem2_r <= ge2 ? sub2[PW-1:0] : sh2[PW-1:0];
      q1_r   <= {q1_r[PW-2:0], ge1};
      q2_r   <= {q2_r[PW-2:0], ge2};
    end
    if (cmd.out_load) begin
      res_num_r <= neg_r ? (~q1_r + 1'b1) : q1_r;
      res_den_r <= (q1_r == '0) ? {{(PW-3){1'b0}}, 1'b1} : q2_r[PW-3:0];
    end
  end

  assign sts.reduce_only = kind_r[1];
  assign sts.gcd_done    = (u_r == '0);
  assign res_num         = res_num_r;
  assign res_den         = res_den_r;

  a_gcd_v_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_step |-> v_r != '0)
    else $error("gcd operand v reached zero");

  a_gcd_no_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_step |-> u_r != '0)
    else $error("gcd stepped after completion");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> g_r != '0)
    else $error("division by zero divisor");

endmodule

[sv/rasr_ctrl.sv]
module rasr_ctrl import rasr_pkg::*; #(
  parameter int W = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  rasr_sts_t sts,
  output rasr_cmd_t cmd
);

  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_MUL3  = 4'd3;
  localparam logic [3:0] S_GINIT = 4'd4;
  localparam logic [3:0] S_GCD   = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovld_r, ovld_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AN_BD;
        state_nxt   = sts.reduce_only ? S_GINIT : S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BN_AD;
        state_nxt   = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AD_BD;
        state_nxt   = S_GINIT;
      end
      S_GINIT: begin
        cmd.gcd_init = 1'b1;
        state_nxt    = S_GCD;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          state_nxt = S_DINIT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(PW - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ovld_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (out_tready) begin
      ovld_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      ovld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;

endmodule

[sv/rational_add_sub_reduce.sv]
// Rational add / subtract / reduce. Each input beat carries two fractions
// a = a_num/a_den and b = b_num/b_den (signed numerators, positive
// denominators; a zero denominator counts as one) and an operation in
// in_tuser: add, subtract, or reduce a alone (code 3 also reduces). The
// block cross-multiplies, then divides numerator and denominator by their
// GCD, giving lowest terms with a positive denominator; a zero numerator
// comes out as 0/1. One item is worked at a time. At OPERAND_WIDTH = W an
// item passes through the shared multiplier (a_num*b_den, b_num*a_den and
// a_den*b_den in turn, the last two skipped for reduce), up to 4W-3 binary
// GCD steps (data dependent, at least one bit stripped per cycle), restoring
// division (both quotients in parallel) and the control states. A finished
// result sits in the output register, so the next beat is taken while it
// waits for out_tready.
module rational_add_sub_reduce import rasr_pkg::*; #(
  parameter int OPERAND_WIDTH = 32,
  localparam int W      = OPERAND_WIDTH,
  localparam int IN_TW  = ((4 * W - 2 + 7) / 8) * 8,
  localparam int OUT_TW = ((4 * W - 2 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // a_num, a_den, b_num, b_den, zero pad
  input  logic [1:0]        in_tuser,   // kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata   // res_num, res_den, zero pad
);

  rasr_cmd_t         cmd;
  rasr_sts_t         sts;
  logic [2*W-1:0]    res_num;
  logic [2*W-3:0]    res_den;

  // controller: sequences multiply, GCD and divide, owns the handshakes
  rasr_ctrl #(.W(W)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: unpack the beat here, fields from the lowest bit up
  rasr_dp #(.W(W)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_kind  (in_tuser),
    .in_a_num (in_tdata[W-1:0]),
    .in_a_den (in_tdata[2*W-2:W]),
    .in_b_num (in_tdata[3*W-2:2*W-1]),
    .in_b_den (in_tdata[4*W-3:3*W-1]),
    .res_num  (res_num),
    .res_den  (res_den)
  );

  // pack the result, numerator lowest, pad the top with zeros
  assign out_tdata = {{(OUT_TW - (4 * W - 2)){1'b0}}, res_den, res_num};

endmodule

[test/rational_add_sub_reduce_chk.sv]
`timescale 1ns / 100ps

module rational_add_sub_reduce_chk import rasr_pkg::*; #(
  parameter int W  = 32,
  localparam int TW = ((4 * W - 2 + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tready,
  input  logic [TW-1:0] in_tdata,   // a_num, a_den, b_num, b_den, zero pad
  input  logic [1:0]    in_tuser,   // kind
  input  logic          out_tvalid,
  input  logic          out_tready,
  input  logic [TW-1:0] out_tdata,  // res_num, res_den, zero pad
  output int            mismatch_count,
  output int            fraction_backlog,
  output int            fractions_checked
);

  typedef struct packed {
    logic [63:0] num;
    logic [61:0] den;
  } fraction_t;

  fraction_t lowest_terms_q[$];

  // Cross-multiply (or take a alone), then divide through by the gcd of the
  // magnitudes; a zero denominator on the way in counts as one.
  function automatic fraction_t lowest_terms(logic [1:0] kind, logic [TW-1:0] beat);
    logic [63:0] an, ad, bn, bd, num, den, mag, x, y, t;
    logic        neg;
    fraction_t   r;
    an = {{(64 - W){beat[W-1]}}, beat[W-1:0]};
    ad = 64'(beat[2*W-2:W]);
    bn = {{(64 - W){beat[3*W-2]}}, beat[3*W-2:2*W-1]};
    bd = 64'(beat[4*W-3:3*W-1]);
    if (ad == 0) ad = 64'd1;
    if (bd == 0) bd = 64'd1;
    if (kind == KIND_ADD || kind == KIND_SUB) begin
      num = (kind == KIND_ADD) ? an * bd + ad * bn : an * bd - ad * bn;
      den = ad * bd;
    end else begin
      num = an;
      den = ad;
    end
    neg = num[63];
    mag = neg ? -num : num;
    x = mag;
    y = den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 0) x = 64'd1;
    mag = mag / x;
    den = den / x;
    if (mag == 0) den = 64'd1;
    r.num = neg ? -mag : mag;
    r.den = den[61:0];
    return r;
  endfunction

  always @(posedge clk) begin
    fraction_t want;
    fraction_t got;
    if (!rst_n) begin
      lowest_terms_q.delete();
    end else begin
      // retire results before queueing new work
      if (out_tvalid && out_tready) begin
        got.num = out_tdata[63:0];
        got.den = out_tdata[125:64];
        if (lowest_terms_q.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none, got %0d/%0d",
                   $time, $signed(got.num), got.den);
          mismatch_count++;
        end else begin
          want = lowest_terms_q.pop_front();
          fractions_checked++;
          if (got.num !== want.num) begin
            $display("%0t: res_num expected %0d, got %0d",
                     $time, $signed(want.num), $signed(got.num));
            mismatch_count++;
          end
          if (got.den !== want.den) begin
            $display("%0t: res_den expected %0d, got %0d", $time, want.den, got.den);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        lowest_terms_q.push_back(lowest_terms(in_tuser, in_tdata));
    end
    fraction_backlog = lowest_terms_q.size();
  end

endmodule

[test/rational_add_sub_reduce_tb.sv]
`timescale 1ns / 100ps

module rational_add_sub_reduce_tb;
  import rasr_pkg::*;

  localparam int W  = 32;
  localparam int TW = ((4 * W - 2 + 7) / 8) * 8;

  // spare operation code; the block treats it as a reduce
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [31:0] NUM_MIN = 32'h8000_0000;
  localparam logic [31:0] NUM_MAX = 32'h7fff_ffff;
  localparam logic [30:0] DEN_MAX = 31'h7fff_ffff;

  // Allow far longer than an item takes inside the block, for stalls on
  // either side, before calling the run hung.
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 250;
  localparam int RANDOM_PER_PHASE = 500;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_tvalid  = 1'b0;
  logic          in_tready;
  logic [TW-1:0] in_tdata   = '0;   // a_num, a_den, b_num, b_den, zero pad
  logic [1:0]    in_tuser   = KIND_ADD;  // kind
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [TW-1:0] out_tdata;         // res_num, res_den, zero pad

  int mismatch_count;
  int fraction_backlog;
  int fractions_checked;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int beats_by_kind[4];
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  rational_add_sub_reduce #(
    .OPERAND_WIDTH(W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  rational_add_sub_reduce_chk #(
    .W(W)
  ) i_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .mismatch_count   (mismatch_count),
    .fraction_backlog (fraction_backlog),
    .fractions_checked(fractions_checked)
  );

  // Receiver: drop tready for the current share of cycles, fresh each edge.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, fraction_backlog);
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one beat, idling beforehand at the current rate, and hold it until
  // taken. Valid stays high on return so back-to-back beats need no toggle.
  task automatic send_beat(input logic [1:0] kind, input logic [31:0] an,
                           input logic [30:0] ad, input logic [31:0] bn,
                           input logic [30:0] bd);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, bd, bn, ad, an};
    beats_by_kind[kind]++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the sender back until every outstanding result has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (fraction_backlog != 0) @(posedge clk);
  endtask

  // Mostly full-range operations; weight toward add and subtract.
  function automatic logic [1:0] pick_kind();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return KIND_ADD;
    if (sel < 7) return KIND_SUB;
    if (sel < 9) return KIND_RED;
    return KIND_SPARE;
  endfunction

  // Full-range numerators, plus small ones so that common factors turn up,
  // plus the extremes.
  function automatic logic [31:0] pick_num();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom();
    if (sel < 8) return 32'(int'($urandom_range(200)) - 100);
    case ($urandom_range(4))
      0:       return NUM_MIN;
      1:       return NUM_MAX;
      2:       return '1;
      3:       return '0;
      default: return 32'd1;
    endcase
  endfunction

  // Denominators: full range, small, powers of two, and zero, one and max.
  function automatic logic [30:0] pick_den();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return 31'($urandom());
    if (sel < 7) return 31'($urandom_range(64, 1));
    if (sel == 7) return 31'(1) << $urandom_range(30);
    case ($urandom_range(3))
      0:       return '0;
      1:       return DEN_MAX;
      default: return 31'd1;
    endcase
  endfunction

  task automatic random_phase(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_beat(pick_kind(), pick_num(), pick_den(), pick_num(), pick_den());
      // now and then let the pipeline run dry
      if ($urandom_range(99) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 10;
    rx_idle_pct = 84;

    // directed: plain sums, cancellation, reduction, integer addend
    send_beat(KIND_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
    send_beat(KIND_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
    send_beat(KIND_SUB, 32'd1, 31'd3, 32'd1, 31'd2);
    send_beat(KIND_RED, 32'd6, 31'd4, 32'd0, 31'd0);
    send_beat(KIND_RED, -32'sd6, 31'd4, NUM_MAX, DEN_MAX);
    send_beat(KIND_RED, 32'd0, 31'd7, 32'd5, 31'd3);
    send_beat(KIND_ADD, 32'd3, 31'd4, 32'd2, 31'd1);
    send_beat(KIND_ADD, -32'sd7, 31'd1, 32'd7, 31'd1);
    // directed: zero denominators count as one, all-zero item gives 0/1
    send_beat(KIND_ADD, 32'd5, 31'd0, 32'd1, 31'd0);
    send_beat(KIND_SUB, 32'd0, 31'd0, 32'd0, 31'd0);
    send_beat(KIND_RED, 32'd9, 31'd0, 32'd0, 31'd0);
    // directed: spare kind code behaves as reduce, b ignored
    send_beat(KIND_SPARE, 32'd12, 31'd18, NUM_MIN, 31'd5);
    send_beat(KIND_SPARE, NUM_MIN, DEN_MAX, '1, '0);
    // directed: field extremes, widest intermediate values
    send_beat(KIND_ADD, NUM_MIN, 31'd1, NUM_MIN, 31'd1);
    send_beat(KIND_ADD, NUM_MAX, 31'd1, NUM_MAX, 31'd1);
    send_beat(KIND_ADD, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);
    send_beat(KIND_SUB, NUM_MIN, DEN_MAX, NUM_MAX, DEN_MAX);
    send_beat(KIND_SUB, NUM_MIN, DEN_MAX, NUM_MAX, DEN_MAX - 31'd1);
    send_beat(KIND_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX - 31'd1);
    send_beat(KIND_SUB, NUM_MAX, 31'd1, NUM_MIN, 31'd1);
    send_beat(KIND_RED, NUM_MIN, 31'h4000_0000, 32'd0, 31'd1);
    send_beat(KIND_RED, NUM_MAX, DEN_MAX - 31'd1, 32'd0, 31'd1);
    send_beat(KIND_RED, '1, DEN_MAX, '1, DEN_MAX);
    drain_results();

    // random: sender sparse idling with a slow receiver, then the reverse,
    // then both flat out
    random_phase(10, 84);
    random_phase(84, 10);
    random_phase(0, 0);

    rx_idle_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d beats: %0d add, %0d subtract, %0d reduce, %0d with the spare code.",
             beats_by_kind[0] + beats_by_kind[1] + beats_by_kind[2] + beats_by_kind[3],
             beats_by_kind[KIND_ADD], beats_by_kind[KIND_SUB], beats_by_kind[KIND_RED],
             beats_by_kind[KIND_SPARE]);
    $display("%0d results compared under 10/84, 84/10 and no idling, %0d mismatches.",
             fractions_checked, mismatch_count);
    if (mismatch_count == 0 && fraction_backlog == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
sv/rasr_pkg.sv
sv/rasr_dp.sv
sv/rasr_ctrl.sv
sv/rational_add_sub_reduce.sv
test/rational_add_sub_reduce_chk.sv
test/rational_add_sub_reduce_tb.sv
